// ===== rtl/mwo_pkg.sv =====
package mwo_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_WHEELS = 4;

  localparam int W_FL = 0;
  localparam int W_FR = 1;
  localparam int W_RL = 2;
  localparam int W_RR = 3;

  // Tick quotient carries 40 fraction bits before rounding to FRAC_BITS
  localparam int TICK_SHR = 40 - FRAC_BITS;
  localparam int TICK_QW = TICK_SHR + 33;
  localparam int RPM_QW = 33;
  localparam int YAW_QW = 33;
  localparam int LIN_SHR = FRAC_BITS + 2;

  localparam int DIV_QW = TICK_QW;
  localparam int DIV_RW = 56;
  localparam int DIV_CW = $clog2(DIV_QW + 1);
  localparam int NUM_W = 96;
  localparam int PROD_W = 66;
  localparam int SAT_W = 64;
  localparam int DEN_RPM_W = 14;

  // 2*pi in Q40 times one million (microseconds to seconds)
  localparam logic [62:0] TWO_PI_US = 63'd6908435304715000000;
  localparam logic [31:0] TWO_PI_US_LO = TWO_PI_US[31:0];
  localparam logic [30:0] TWO_PI_US_HI = TWO_PI_US[62:32];

  localparam logic [15:0] CPR_RST = 16'd40;
  localparam logic [7:0] GEAR_RST = 8'd5;
  localparam logic [31:0] RADIUS_RST = 32'(((64'd7 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [31:0] AXLE_RST = 32'(((64'd369 << FRAC_BITS) + 64'd500) / 64'd1000);

  typedef struct packed {
    logic go;
    logic zero;
    logic [DIV_RW-1:0] den_tick;
    logic [DEN_RPM_W-1:0] den_rpm;
  } lane_cmd_t;

  typedef struct packed {
    logic done;
    logic signed [31:0] tick_speed;
    logic signed [31:0] scaled_rpm;
  } lane_res_t;

  // Apply sign to a magnitude and clamp to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic neg, input logic [SAT_W-1:0] m);
    logic [31:0] r;
    if (neg) begin
      if (m > SAT_W'(64'h8000_0000)) r = 32'h8000_0000;
      else r = ~m[31:0] + 32'd1;
    end else begin
      if (m > SAT_W'(64'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
      else r = m[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/mwo_div.sv =====
module mwo_div import mwo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_RW-1:0] rem_init,
  input  logic [DIV_QW-1:0] num,
  input  logic [DIV_RW-1:0] den,
  input  logic [DIV_CW-1:0] steps,
  output logic              busy,
  output logic [DIV_QW-1:0] quot
);

  logic [DIV_CW-1:0] cnt;
  logic [DIV_RW-1:0] rem;
  logic [DIV_QW-1:0] num_sr;
  logic [DIV_RW:0]   rem_sh;
  logic [DIV_RW:0]   diff;
  logic              ge;

  assign rem_sh = {rem, num_sr[DIV_QW-1]};
  assign diff = rem_sh - {1'b0, den};
  assign ge = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= steps;
    end else if (busy) begin
      cnt <= cnt - DIV_CW'(1);
      if (cnt == DIV_CW'(1)) busy <= 1'b0;
    end
  end

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      num_sr <= num;
      quot <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DIV_RW-1:0] : rem_sh[DIV_RW-1:0];
      num_sr <= {num_sr[DIV_QW-2:0], 1'b0};
      quot <= {quot[DIV_QW-2:0], ge};
    end
  end

endmodule

// ===== rtl/mwo_lane.sv =====
module mwo_lane import mwo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lane_cmd_t          cmd,
  input  logic signed [32:0] delta,
  input  logic signed [31:0] rpm,
  output lane_res_t          res
);

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_MLO  = 5'b00010,
    L_MHI  = 5'b00100,
    L_LOAD = 5'b01000,
    L_DIV  = 5'b10000
  } lane_state_t;

  localparam logic [TICK_QW:0] TICK_HALF = (TICK_QW + 1)'(1) << (TICK_SHR - 1);

  lane_state_t state, state_next;

  logic [32:0]       d_u;
  logic [31:0]       rpm_u;
  logic [32:0]       d_mag;
  logic [31:0]       rpm_mag;
  logic              neg_t, neg_r, ovf_t;
  logic [32:0]       mag_t;
  logic [NUM_W-1:0]  acc;
  logic [31:0]       k_half;
  logic [64:0]       prod;
  logic [DIV_RW-1:0] tick_rem0;
  logic              busy_t, busy_r;
  logic [DIV_QW-1:0] q_t, q_r;
  logic [TICK_QW:0]  tick_sum, tick_rnd;
  logic [RPM_QW:0]   rpm_sum;
  logic [RPM_QW-1:0] rpm_rnd;
  logic              finish;
  logic              done_r;
  logic [31:0]       ts_r, rs_r;

  assign d_u = delta;
  assign rpm_u = rpm;
  assign d_mag = d_u[32] ? (~d_u + 33'd1) : d_u;
  assign rpm_mag = rpm_u[31] ? (~rpm_u + 32'd1) : rpm_u;

  // One 33x32 multiplier, two passes over the halves of the constant
  assign k_half = (state == L_MLO) ? TWO_PI_US_LO : {1'b0, TWO_PI_US_HI};
  assign prod = 65'(mag_t) * 65'(k_half);

  assign tick_rem0 = DIV_RW'(acc >> TICK_QW);

  mwo_div u_div_rpm (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == L_IDLE) && cmd.go),
    .rem_init ('0),
    .num      ({rpm_mag, 1'b0, {(DIV_QW - RPM_QW){1'b0}}}),
    .den      (DIV_RW'(cmd.den_rpm)),
    .steps    (DIV_CW'(RPM_QW)),
    .busy     (busy_r),
    .quot     (q_r)
  );

  mwo_div u_div_tick (
    .clk      (clk),
    .rst      (rst),
    .start    (state == L_LOAD),
    .rem_init (tick_rem0),
    .num      (acc[DIV_QW-1:0]),
    .den      (cmd.den_tick),
    .steps    (DIV_CW'(TICK_QW)),
    .busy     (busy_t),
    .quot     (q_t)
  );

  assign tick_sum = {1'b0, q_t[TICK_QW-1:0]} + TICK_HALF;
  assign tick_rnd = tick_sum >> TICK_SHR;
  assign rpm_sum = {1'b0, q_r[RPM_QW-1:0]} + (RPM_QW + 1)'(1);
  assign rpm_rnd = rpm_sum[RPM_QW:1];

  assign finish = (state == L_DIV) && !busy_t && !busy_r;

  always_comb begin
    state_next = state;
    case (state)
      L_IDLE: if (cmd.go) state_next = L_MLO;
      L_MLO:  state_next = L_MHI;
      L_MHI:  state_next = L_LOAD;
      L_LOAD: state_next = L_DIV;
      L_DIV:  if (finish) state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      state <= state_next;
      done_r <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == L_IDLE) && cmd.go) begin
      neg_t <= d_u[32];
      mag_t <= d_mag;
      neg_r <= rpm_u[31];
    end
    if (state == L_MLO) acc <= NUM_W'(prod);
    if (state == L_MHI) acc <= acc + (NUM_W'(prod) << 32);
    // quotient would not fit: saturate
    if (state == L_LOAD) ovf_t <= (tick_rem0 >= cmd.den_tick);
    if (finish) begin
      ts_r <= cmd.zero ? 32'd0 :
              sat32(neg_t, ovf_t ? {SAT_W{1'b1}} : SAT_W'(tick_rnd));
      rs_r <= sat32(neg_r, SAT_W'(rpm_rnd));
    end
  end

  always_comb begin
    res.done = done_r;
    res.tick_speed = ts_r;
    res.scaled_rpm = rs_r;
  end

endmodule

// ===== rtl/mwo_merge.sv =====
module mwo_merge import mwo_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [NUM_WHEELS-1:0][31:0]  wheel,
  input  logic [31:0]                  radius,
  input  logic [31:0]                  axle,
  output logic                         done,
  output logic signed [31:0]           vx,
  output logic signed [31:0]           vy,
  output logic signed [31:0]           wz
);

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001,
    M_PX   = 6'b000010,
    M_PY   = 6'b000100,
    M_PW   = 6'b001000,
    M_LOAD = 6'b010000,
    M_DIV  = 6'b100000
  } merge_state_t;

  localparam logic [PROD_W:0] LIN_HALF = (PROD_W + 1)'(1) << (LIN_SHR - 1);

  function automatic logic [33:0] mag_of(input logic [34:0] s);
    logic [34:0] u;
    u = s;
    if (u[34]) u = ~u + 35'd1;
    return u[33:0];
  endfunction

  merge_state_t state, state_next;

  logic signed [34:0] ws [NUM_WHEELS];
  logic signed [34:0] s_x, s_y, s_z;
  logic [33:0]        mag_x, mag_y, mag_z, mag_sel;
  logic               neg_x, neg_y, neg_z, ovf_z;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    lin_sum, lin_rnd;
  logic [DIV_RW-1:0]  yaw_rem0, yaw_den;
  logic               busy;
  logic [DIV_QW-1:0]  q;
  logic [YAW_QW:0]    yaw_sum;
  logic [YAW_QW-1:0]  yaw_rnd;
  logic               finish;

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      ws[i] = 35'(signed'(wheel[i]));
    end
  end

  assign s_x = ws[W_FL] + ws[W_FR] + ws[W_RL] + ws[W_RR];
  assign s_y = ws[W_FR] - ws[W_FL] + ws[W_RL] - ws[W_RR];
  assign s_z = ws[W_FR] + ws[W_RR] - ws[W_FL] - ws[W_RL];

  always_comb begin
    case (state)
      M_PY: mag_sel = mag_y;
      M_PW: mag_sel = mag_z;
      default: mag_sel = mag_x;
    endcase
  end

  assign lin_sum = {1'b0, prod} + LIN_HALF;
  assign lin_rnd = lin_sum >> LIN_SHR;

  // Yaw numerator is twice the product; divide by 4*(L+W), then halve with rounding
  assign yaw_rem0 = DIV_RW'(prod >> (YAW_QW - 1));
  assign yaw_den = DIV_RW'({axle, 2'b00});

  mwo_div u_div_yaw (
    .clk      (clk),
    .rst      (rst),
    .start    (state == M_LOAD),
    .rem_init (yaw_rem0),
    .num      ({prod[YAW_QW-2:0], 1'b0, {(DIV_QW - YAW_QW){1'b0}}}),
    .den      (yaw_den),
    .steps    (DIV_CW'(YAW_QW)),
    .busy     (busy),
    .quot     (q)
  );

  assign yaw_sum = {1'b0, q[YAW_QW-1:0]} + (YAW_QW + 1)'(1);
  assign yaw_rnd = yaw_sum[YAW_QW:1];

  assign finish = (state == M_DIV) && !busy;

  always_comb begin
    state_next = state;
    case (state)
      M_IDLE: if (go) state_next = M_PX;
      M_PX:   state_next = M_PY;
      M_PY:   state_next = M_PW;
      M_PW:   state_next = M_LOAD;
      M_LOAD: state_next = M_DIV;
      M_DIV:  if (finish) state_next = M_IDLE;
      default: state_next = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == M_IDLE) && go) begin
      mag_x <= mag_of(s_x);
      mag_y <= mag_of(s_y);
      mag_z <= mag_of(s_z);
      neg_x <= s_x[34];
      neg_y <= s_y[34];
      neg_z <= s_z[34];
    end
    if ((state == M_PX) || (state == M_PY) || (state == M_PW)) begin
      prod <= PROD_W'(mag_sel) * PROD_W'(radius);
    end
    if (state == M_PY) vx <= sat32(neg_x, SAT_W'(lin_rnd));
    if (state == M_PW) vy <= sat32(neg_y, SAT_W'(lin_rnd));
    if (state == M_LOAD) ovf_z <= (yaw_rem0 >= yaw_den);
    if (finish) wz <= sat32(neg_z, ovf_z ? {SAT_W{1'b1}} : SAT_W'(yaw_rnd));
  end

endmodule

// ===== rtl/mecanum_wheel_odometry_core.sv =====
// A result leaves on out_valid after its input passes S_CG, S_DEN, the wheel lanes (tick-speed
// dividers, one quotient bit per cycle over TICK_QW bits), the merge stage (yaw divider) and
// S_OUT, which can wait on out_ready. A new sample is taken only in S_IDLE, after the result is loaded.
// The first sample after reset only records positions and stamp.
// Reset (rst, synchronous, active high) clears the primed flag, handshake state and config
// registers to defaults; stored positions and stamp are undefined until the first sample.
module mecanum_wheel_odometry_core import mwo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        stamp_us,
  input  logic signed [31:0] pos_front_left,
  input  logic signed [31:0] pos_front_right,
  input  logic signed [31:0] pos_rear_left,
  input  logic signed [31:0] pos_rear_right,
  input  logic signed [31:0] rpm_front_left,
  input  logic signed [31:0] rpm_front_right,
  input  logic signed [31:0] rpm_rear_left,
  input  logic signed [31:0] rpm_rear_right,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] tick_speed_fl,
  output logic signed [31:0] tick_speed_fr,
  output logic signed [31:0] tick_speed_rl,
  output logic signed [31:0] tick_speed_rr,
  output logic signed [31:0] scaled_rpm_fl,
  output logic signed [31:0] scaled_rpm_fr,
  output logic signed [31:0] scaled_rpm_rl,
  output logic signed [31:0] scaled_rpm_rr,
  output logic signed [31:0] body_vx,
  output logic signed [31:0] body_vy,
  output logic signed [31:0] body_wz,
  output logic               zero_interval
);

  localparam logic [2:0] CFG_USE_TICK = 3'd0;
  localparam logic [2:0] CFG_CPR      = 3'd1;
  localparam logic [2:0] CFG_GEAR     = 3'd2;
  localparam logic [2:0] CFG_RADIUS   = 3'd3;
  localparam logic [2:0] CFG_AXLE     = 3'd4;

  localparam logic [DEN_RPM_W-1:0] RPM_SCALE = DEN_RPM_W'(60);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CG    = 6'b000010,
    S_DEN   = 6'b000100,
    S_LANE  = 6'b001000,
    S_MERGE = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic        use_tick_mode;
  logic [15:0] counts_per_rev;
  logic [7:0]  gear_ratio;
  logic [31:0] wheel_radius_q16;
  logic [31:0] axle_sum_q16;

  logic [15:0] cpr_eff;
  logic [7:0]  gr_eff;
  logic [31:0] ax_eff;

  logic signed [31:0] pos_in [NUM_WHEELS];
  logic signed [31:0] rpm_in [NUM_WHEELS];
  logic signed [31:0] last_pos [NUM_WHEELS];
  logic [31:0]        last_stamp;
  logic               primed;

  logic [31:0]          dt;
  logic                 zero;
  logic signed [32:0]   delta [NUM_WHEELS];
  logic signed [31:0]   rpm_q [NUM_WHEELS];
  logic [23:0]          cg;
  logic [DIV_RW-1:0]    den_tick;
  logic [DEN_RPM_W-1:0] den_rpm;

  logic      lane_go, merge_go, merge_done;
  lane_cmd_t lane_cmd;
  lane_res_t lane_res [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]       lane_done_vec;
  logic [NUM_WHEELS-1:0][31:0] w_sel;
  logic signed [31:0] vx, vy, wz;

  logic accept, load;

  assign pos_in[W_FL] = pos_front_left;
  assign pos_in[W_FR] = pos_front_right;
  assign pos_in[W_RL] = pos_rear_left;
  assign pos_in[W_RR] = pos_rear_right;
  assign rpm_in[W_FL] = rpm_front_left;
  assign rpm_in[W_FR] = rpm_front_right;
  assign rpm_in[W_RL] = rpm_rear_left;
  assign rpm_in[W_RR] = rpm_rear_right;

  // Zero divisor registers behave as one
  assign cpr_eff = (counts_per_rev == 16'd0) ? 16'd1 : counts_per_rev;
  assign gr_eff = (gear_ratio == 8'd0) ? 8'd1 : gear_ratio;
  assign ax_eff = (axle_sum_q16 == 32'd0) ? 32'd1 : axle_sum_q16;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign load = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      use_tick_mode <= 1'b0;
      counts_per_rev <= CPR_RST;
      gear_ratio <= GEAR_RST;
      wheel_radius_q16 <= RADIUS_RST;
      axle_sum_q16 <= AXLE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_USE_TICK: use_tick_mode <= cfg_wr_data[0];
        CFG_CPR:      counts_per_rev <= cfg_wr_data[15:0];
        CFG_GEAR:     gear_ratio <= cfg_wr_data[7:0];
        CFG_RADIUS:   wheel_radius_q16 <= cfg_wr_data;
        CFG_AXLE:     axle_sum_q16 <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept && primed) state_next = S_CG;
      S_CG:    state_next = S_DEN;
      S_DEN:   state_next = S_LANE;
      S_LANE:  if (&lane_done_vec) state_next = S_MERGE;
      S_MERGE: if (merge_done) state_next = S_OUT;
      S_OUT:   if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      primed <= 1'b0;
      lane_go <= 1'b0;
      merge_go <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) primed <= 1'b1;
      lane_go <= (state == S_DEN);
      merge_go <= (state == S_LANE) && (&lane_done_vec);
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Capture deltas against the previous sample, then overwrite it
  always_ff @(posedge clk) begin
    if (accept) begin
      last_stamp <= stamp_us;
      dt <= stamp_us - last_stamp;
      zero <= (stamp_us == last_stamp);
      for (int i = 0; i < NUM_WHEELS; i++) begin
        last_pos[i] <= pos_in[i];
        delta[i] <= 33'(pos_in[i]) - 33'(last_pos[i]);
        rpm_q[i] <= rpm_in[i];
      end
    end
    if (state == S_CG) begin
      cg <= 24'(cpr_eff) * 24'(gr_eff);
      den_rpm <= DEN_RPM_W'(gr_eff) * RPM_SCALE;
    end
    if (state == S_DEN) den_tick <= {24'd0, dt} * {32'd0, cg};
  end

  always_comb begin
    lane_cmd.go = lane_go;
    lane_cmd.zero = zero;
    lane_cmd.den_tick = den_tick;
    lane_cmd.den_rpm = den_rpm;
  end

  for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_lane
    mwo_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .cmd   (lane_cmd),
      .delta (delta[g]),
      .rpm   (rpm_q[g]),
      .res   (lane_res[g])
    );
    assign lane_done_vec[g] = lane_res[g].done;
    assign w_sel[g] = use_tick_mode ? lane_res[g].tick_speed : lane_res[g].scaled_rpm;
  end

  mwo_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .go     (merge_go),
    .wheel  (w_sel),
    .radius (wheel_radius_q16),
    .axle   (ax_eff),
    .done   (merge_done),
    .vx     (vx),
    .vy     (vy),
    .wz     (wz)
  );

  always_ff @(posedge clk) begin
    if (load) begin
      tick_speed_fl <= lane_res[W_FL].tick_speed;
      tick_speed_fr <= lane_res[W_FR].tick_speed;
      tick_speed_rl <= lane_res[W_RL].tick_speed;
      tick_speed_rr <= lane_res[W_RR].tick_speed;
      scaled_rpm_fl <= lane_res[W_FL].scaled_rpm;
      scaled_rpm_fr <= lane_res[W_FR].scaled_rpm;
      scaled_rpm_rl <= lane_res[W_RL].scaled_rpm;
      scaled_rpm_rr <= lane_res[W_RR].scaled_rpm;
      body_vx <= vx;
      body_vy <= vy;
      body_wz <= wz;
      zero_interval <= zero;
    end
  end

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (lane_done_vec == '0) || (lane_done_vec == '1))
    else $error("wheel lanes finished out of step");

  a_merge_in_phase: assert property (@(posedge clk) disable iff (rst)
    merge_done |-> (state == S_MERGE))
    else $error("merge stage finished outside its phase");

  a_zero_ticks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_interval) |-> ((tick_speed_fl == 32'sd0) && (tick_speed_fr == 32'sd0)
      && (tick_speed_rl == 32'sd0) && (tick_speed_rr == 32'sd0)))
    else $error("tick speeds not forced to zero on a zero interval");

  a_prime_only: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && !primed) |=> (state == S_IDLE && primed))
    else $error("priming transaction did not return to idle primed");

endmodule

// ===== sim/mecanum_wheel_odometry_core_test.sv =====
`timescale 1ns / 1ps

module mecanum_wheel_odometry_core_test;
  import mwo_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 150;
  localparam int PHASES = 6;
  localparam int RANDOM_PER_PHASE = 140;
  localparam int FRAC = 16;
  localparam int TICK_SHIFT = 40 - FRAC;
  localparam logic [127:0] TWO_PI_Q40 = 128'd6908435304715;

  typedef enum logic [2:0] {
    REG_TICK_MODE,
    REG_COUNTS_PER_REV,
    REG_GEAR_RATIO,
    REG_WHEEL_RADIUS,
    REG_AXLE_SUM
  } cfg_reg_e;

  // wheel order in every array: front left, front right, rear left, rear right
  typedef struct packed {
    logic [31:0] stamp;
    logic [3:0][31:0] pos;
    logic [3:0][31:0] rpm;
  } sample_t;

  typedef struct packed {
    logic [3:0][31:0] tick;
    logic [3:0][31:0] srpm;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] wz;
    logic zero;
  } twist_t;

  class odometry_tracker;
    bit tick_mode;
    logic [15:0] cpr;
    logic [7:0] gear;
    logic [31:0] radius;
    logic [31:0] axle;
    bit primed;
    logic [31:0] last_stamp;
    logic [3:0][31:0] last_pos;
    twist_t pending_twists[$];
    int mismatches;
    string tags [4] = '{"fl", "fr", "rl", "rr"};

    function new();
      tick_mode = 1'b0;
      cpr = 16'd40;
      gear = 8'd5;
      radius = 32'd4588;
      axle = 32'd24183;
      primed = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] val);
      case (idx)
        REG_TICK_MODE: tick_mode = val[0];
        REG_COUNTS_PER_REV: cpr = val[15:0];
        REG_GEAR_RATIO: gear = val[7:0];
        REG_WHEEL_RADIUS: radius = val;
        REG_AXLE_SUM: axle = val;
        default: ;
      endcase
    endfunction

    function logic [127:0] magnitude(logic signed [63:0] v);
      logic [127:0] m;
      if (v < 0) m = -v;
      else m = v;
      return m;
    endfunction

    function logic [31:0] clamp32(bit neg, logic [127:0] mag);
      if (neg) return (mag > 128'h8000_0000) ? 32'h8000_0000 : ~mag[31:0] + 32'd1;
      return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    // ticks per microsecond to rad/s: truncate at 40 fraction bits, then round
    function logic [31:0] wheel_rate(logic signed [63:0] delta, logic [63:0] den);
      logic [127:0] quo;
      quo = magnitude(delta) * 128'd1000000 * TWO_PI_Q40 / den;
      quo = (quo + (128'd1 << (TICK_SHIFT - 1))) >> TICK_SHIFT;
      return clamp32(delta < 0, quo);
    endfunction

    function logic [31:0] scale_rpm(logic signed [31:0] rpm, logic [63:0] div);
      logic [127:0] m;
      m = (magnitude(rpm) * 2 / div + 1) >> 1;
      return clamp32(rpm < 0, m);
    endfunction

    function logic [31:0] body_linear(logic signed [63:0] s);
      logic [127:0] quo;
      quo = (magnitude(s) * radius + (128'd1 << (FRAC + 1))) >> (FRAC + 2);
      return clamp32(s < 0, quo);
    endfunction

    function logic [31:0] body_yaw(logic signed [63:0] s, logic [63:0] ax);
      logic [127:0] quo;
      quo = ((magnitude(s) * radius * 2) / (ax * 4) + 1) >> 1;
      return clamp32(s < 0, quo);
    endfunction

    function void note_sample(sample_t s);
      logic [31:0] span;
      logic [63:0] dt;
      logic [63:0] gr;
      logic [63:0] cp;
      logic [63:0] ax;
      logic signed [63:0] delta;
      logic signed [63:0] w [4];
      bit zero;
      twist_t t;
      if (primed) begin
        span = s.stamp - last_stamp;
        dt = span;
        zero = (span == 32'd0);
        gr = (gear == 8'd0) ? 64'd1 : 64'(gear);
        cp = (cpr == 16'd0) ? 64'd1 : 64'(cpr);
        ax = (axle == 32'd0) ? 64'd1 : 64'(axle);
        for (int i = 0; i < 4; i++) begin
          delta = $signed(s.pos[i]) - $signed(last_pos[i]);
          t.tick[i] = zero ? 32'd0 : wheel_rate(delta, dt * cp * gr);
          t.srpm[i] = scale_rpm(s.rpm[i], 64'd60 * gr);
          w[i] = tick_mode ? $signed(t.tick[i]) : $signed(t.srpm[i]);
        end
        t.vx = body_linear(w[0] + w[1] + w[2] + w[3]);
        t.vy = body_linear(w[1] - w[0] + w[2] - w[3]);
        t.wz = body_yaw(w[1] + w[3] - w[0] - w[2], ax);
        t.zero = zero;
        pending_twists.push_back(t);
      end
      last_pos = s.pos;
      last_stamp = s.stamp;
      primed = 1'b1;
    endfunction

    function void compare(string label, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t %s mismatch: expected %0d (%h) got %0d (%h)", $time, label,
                   $signed(want), want, $signed(got), got);
      end
    endfunction

    function void check_twist(twist_t got);
      twist_t want;
      if (pending_twists.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t result with no sample pending", $time);
        return;
      end
      want = pending_twists.pop_front();
      for (int i = 0; i < 4; i++) begin
        compare({"tick_speed_", tags[i]}, want.tick[i], got.tick[i]);
        compare({"scaled_rpm_", tags[i]}, want.srpm[i], got.srpm[i]);
      end
      compare("body_vx", want.vx, got.vx);
      compare("body_vy", want.vy, got.vy);
      compare("body_wz", want.wz, got.wz);
      compare("zero_interval", 32'(want.zero), 32'(got.zero));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = REG_TICK_MODE;
  logic [31:0] cfg_wr_data = 32'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] stamp_us = 32'd0;
  logic signed [31:0] pos_front_left = 32'sd0;
  logic signed [31:0] pos_front_right = 32'sd0;
  logic signed [31:0] pos_rear_left = 32'sd0;
  logic signed [31:0] pos_rear_right = 32'sd0;
  logic signed [31:0] rpm_front_left = 32'sd0;
  logic signed [31:0] rpm_front_right = 32'sd0;
  logic signed [31:0] rpm_rear_left = 32'sd0;
  logic signed [31:0] rpm_rear_right = 32'sd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] tick_speed_fl;
  logic signed [31:0] tick_speed_fr;
  logic signed [31:0] tick_speed_rl;
  logic signed [31:0] tick_speed_rr;
  logic signed [31:0] scaled_rpm_fl;
  logic signed [31:0] scaled_rpm_fr;
  logic signed [31:0] scaled_rpm_rl;
  logic signed [31:0] scaled_rpm_rr;
  logic signed [31:0] body_vx;
  logic signed [31:0] body_vy;
  logic signed [31:0] body_wz;
  logic zero_interval;

  odometry_tracker tracker;
  twist_t observed;
  sample_t recent;
  int send_idle_pct = 23;
  int recv_idle_pct = 62;

  mecanum_wheel_odometry_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stamp_us(stamp_us),
    .pos_front_left(pos_front_left),
    .pos_front_right(pos_front_right),
    .pos_rear_left(pos_rear_left),
    .pos_rear_right(pos_rear_right),
    .rpm_front_left(rpm_front_left),
    .rpm_front_right(rpm_front_right),
    .rpm_rear_left(rpm_rear_left),
    .rpm_rear_right(rpm_rear_right),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tick_speed_fl(tick_speed_fl),
    .tick_speed_fr(tick_speed_fr),
    .tick_speed_rl(tick_speed_rl),
    .tick_speed_rr(tick_speed_rr),
    .scaled_rpm_fl(scaled_rpm_fl),
    .scaled_rpm_fr(scaled_rpm_fr),
    .scaled_rpm_rl(scaled_rpm_rl),
    .scaled_rpm_rr(scaled_rpm_rr),
    .body_vx(body_vx),
    .body_vy(body_vy),
    .body_wz(body_wz),
    .zero_interval(zero_interval)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always_comb begin
    observed.tick = {tick_speed_rr, tick_speed_rl, tick_speed_fr, tick_speed_fl};
    observed.srpm = {scaled_rpm_rr, scaled_rpm_rl, scaled_rpm_fr, scaled_rpm_fl};
    observed.vx = body_vx;
    observed.vy = body_vy;
    observed.wz = body_wz;
    observed.zero = zero_interval;
  end

  // check the result transaction first, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_twist(observed);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic sample_t make_sample(logic [31:0] stamp, logic [31:0] fl, logic [31:0] fr,
                                          logic [31:0] rl, logic [31:0] rr, logic [31:0] rfl,
                                          logic [31:0] rfr, logic [31:0] rrl,
                                          logic [31:0] rrr);
    sample_t s;
    s.stamp = stamp;
    s.pos = {rr, rl, fr, fl};
    s.rpm = {rrr, rrl, rfr, rfl};
    return s;
  endfunction

  function automatic logic [31:0] spread(int unsigned lim);
    logic [31:0] v;
    v = $urandom_range(lim, 0);
    if ($urandom_range(1, 0) != 0) v = -v;
    return v;
  endfunction

  // mostly a plausible walk of stamps and encoders, with some jumps and repeats
  function automatic sample_t next_sample(sample_t prev);
    sample_t s;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) s.stamp = prev.stamp;
    else if (pick < 8) s.stamp = $urandom;
    else s.stamp = prev.stamp + $urandom_range(100000, 1);
    for (int i = 0; i < 4; i++) begin
      pick = $urandom_range(99);
      if (pick < 5) s.pos[i] = $urandom;
      else if (pick < 10) s.pos[i] = prev.pos[i] + spread(1 << 20);
      else s.pos[i] = prev.pos[i] + spread(3000);
      pick = $urandom_range(99);
      if (pick < 5) s.rpm[i] = $urandom;
      else if (pick < 8) s.rpm[i] = $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else s.rpm[i] = spread(400_000_000);
    end
    return s;
  endfunction

  task automatic push(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    stamp_us <= s.stamp;
    pos_front_left <= s.pos[0];
    pos_front_right <= s.pos[1];
    pos_rear_left <= s.pos[2];
    pos_rear_right <= s.pos[3];
    rpm_front_left <= s.rpm[0];
    rpm_front_right <= s.rpm[1];
    rpm_rear_left <= s.rpm[2];
    rpm_rear_right <= s.rpm[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_sample(s);
    recent = s;
  endtask

  task automatic hold_for_results();
    if (tracker.pending_twists.size() != 0) begin
      in_valid <= 1'b0;
      while (tracker.pending_twists.size() != 0) @(posedge clk);
    end
  endtask

  // drain, then cover a sample still in flight that gives no result
  task automatic settle();
    hold_for_results();
    in_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    tracker.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic load_config(bit mode, logic [15:0] cpr, logic [7:0] gear,
                             logic [31:0] radius, logic [31:0] axle);
    put_reg(REG_TICK_MODE, 32'(mode));
    put_reg(REG_COUNTS_PER_REV, 32'(cpr));
    put_reg(REG_GEAR_RATIO, 32'(gear));
    put_reg(REG_WHEEL_RADIUS, radius);
    put_reg(REG_AXLE_SUM, axle);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: kinematics from scaled rpm
    push(make_sample(32'd1000, 0, 0, 0, 0, 0, 0, 0, 0));
    push(make_sample(32'd2000, 100, -100, 50, -50,
                     32'h03E8_0000, 32'hFC18_0000, 32'h001E_0000, 1));
    // same stamp again: zero interval
    push(make_sample(32'd2000, 150, -80, 0, 7,
                     32'h0001_0000, 32'hFFFF_0000, 0, 32'hFFFF_FFFF));
    push(make_sample(32'd2001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0));
    // largest negative tick step over one microsecond
    push(make_sample(32'd2002, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF));
    // stamp going backwards reads as a long interval
    push(make_sample(32'd0, 0, 0, 0, 0,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    push(make_sample(32'hFFFF_FFFF, 1, 2, 3, 4,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    // stamp wraps to zero: one microsecond
    push(make_sample(32'd0, 1, 2, 3, 4, 32'h0032_8000, 32'hFFCD_8000, 5, -5));
    push(make_sample(32'd1000, -1, -1, -1, -1, 32'h0000_8000, 32'hFFFF_8000, 3, -3));
    settle();

    load_config(1'b1, 16'd40, 8'd5, 32'd4588, 32'd24183);
    push(make_sample(32'd11000, 9, 19, -31, 39,
                     32'h03E8_0000, 32'h03E8_0000, 32'h03E8_0000, 32'h03E8_0000));
    push(make_sample(32'd11000, 20, 20, 20, 20, 0, 0, 0, 0));
    push(make_sample(32'd11001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     0, 0, 0, 0));
    push(make_sample(32'd21001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     0, 0, 0, 0));
    push(make_sample(32'd31001, 32'h7FFF_FFFF - 500, 32'h8000_0000 + 500,
                     32'h7FFF_FFFF - 500, 32'h8000_0000 + 500, 0, 0, 0, 0));

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: load_config(1'b1, 16'd40, 8'd5, 32'd4588, 32'd24183);
        1: load_config(1'b0, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'd1);
        2: load_config(1'b1, 16'd1, 8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // zero divisor registers act as one
        3: load_config(1'b1, 16'd0, 8'd0, 32'h0001_0000, 32'd0);
        4: load_config(1'b0, 16'($urandom_range(65535, 1)), 8'($urandom_range(255, 1)),
                       $urandom, $urandom);
        default: load_config(1'b1, 16'($urandom_range(4096, 256)), 8'($urandom_range(50, 1)),
                             32'($urandom_range(20000, 2000)),
                             32'($urandom_range(60000, 10000)));
      endcase
      send_idle_pct = (phase < 2) ? 23 : (phase < 4) ? 62 : 0;
      recv_idle_pct = (phase < 2) ? 62 : (phase < 4) ? 23 : 0;
      repeat (RANDOM_PER_PHASE) begin
        if ($urandom_range(99) == 0) hold_for_results();
        push(next_sample(recent));
      end
    end

    settle();
    if (tracker.mismatches == 0 && tracker.pending_twists.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
